/* hw/rtl/sqlq_pkg.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sqlq_pkg - shared types and constants of the query lexer
// Token record, scan modes, token kinds, keyword spellings and byte classes.
// ----------------------------------------------------------------------------
package sqlq_pkg;

	// scan modes
	localparam logic [2:0] MODE_IDLE   = 3'd0;
	localparam logic [2:0] MODE_IDENT  = 3'd1;
	localparam logic [2:0] MODE_NUMBER = 3'd2;
	localparam logic [2:0] MODE_STRING = 3'd3;
	localparam logic [2:0] MODE_BANG   = 3'd4;

	// token kinds
	localparam logic [2:0] KIND_IDENT   = 3'd0;
	localparam logic [2:0] KIND_KEYWORD = 3'd1;
	localparam logic [2:0] KIND_NUMBER  = 3'd2;
	localparam logic [2:0] KIND_STRING  = 3'd3;
	localparam logic [2:0] KIND_PUNCT   = 3'd4;
	localparam logic [2:0] KIND_EOF     = 3'd5;
	localparam logic [2:0] KIND_ERROR   = 3'd6;

	// special bytes
	localparam logic [7:0] CH_NUL   = 8'h00;
	localparam logic [7:0] CH_TAB   = 8'h09;
	localparam logic [7:0] CH_LF    = 8'h0A;
	localparam logic [7:0] CH_SPACE = 8'h20;
	localparam logic [7:0] CH_BANG  = 8'h21;
	localparam logic [7:0] CH_QUOTE = 8'h27;
	localparam logic [7:0] CH_EQUAL = 8'h3D;
	localparam logic [7:0] CH_UNDER = 8'h5F;

	// keyword table, unused tail characters are zero
	localparam int KW_COUNT   = 5;
	localparam int KW_MAX_LEN = 6;
	localparam int KW_LEN [KW_COUNT] = '{6, 6, 4, 5, 3};
	localparam logic [7:0] KW_CHARS [KW_COUNT][KW_MAX_LEN] = '{
		'{"s", "e", "l", "e", "c", "t"},
		'{"d", "e", "l", "e", "t", "e"},
		'{"f", "r", "o", "m", 8'h00, 8'h00},
		'{"w", "h", "e", "r", "e", 8'h00},
		'{"a", "n", "d", 8'h00, 8'h00, 8'h00}
	};

	// result queue geometry
	localparam int QUEUE_DEPTH = 8;
	localparam int QPTR_W      = 3;
	localparam int QCNT_W      = 4;
	// input is taken only while this many beats or fewer are queued
	localparam logic [QCNT_W-1:0] QUEUE_ACCEPT_MAX = QCNT_W'(QUEUE_DEPTH - 4);

	// one result beat
	typedef struct packed {
		logic [2:0]  kind;
		logic [15:0] offset;
		logic [15:0] length;
		logic [31:0] value;
		logic [2:0]  code;
		logic        last;
	} token_t;

	// results of one byte, compacted into the low slots
	typedef struct packed {
		logic [1:0]       cnt;
		token_t [1:0]     tok;
	} token_pair_t;

	// scanner status
	typedef struct packed {
		logic [2:0]  mode;
		logic [15:0] pos_lo;
	} scan_status_t;

	function automatic logic is_letter(input logic [7:0] b);
		return (b inside {[8'h61:8'h7A], [8'h41:8'h5A]});
	endfunction

	function automatic logic is_digit(input logic [7:0] b);
		return (b inside {[8'h30:8'h39]});
	endfunction

	function automatic logic is_punct(input logic [7:0] b);
		return (b inside {[8'd33:8'd47], [8'd58:8'd64], [8'd91:8'd96], [8'd123:8'd126]});
	endfunction

	function automatic logic is_blank(input logic [7:0] b);
		return (b inside {CH_SPACE, CH_TAB, CH_LF});
	endfunction

endpackage

/* hw/rtl/sqlq_scan.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sqlq_scan - lexer state and per-byte token logic
// Updates the scan state for one registered byte and forms up to two tokens.
// ----------------------------------------------------------------------------
module sqlq_scan
	import sqlq_pkg::*;
#(
	parameter int MAX_TEXT_LEN    = 65536,
	parameter int KEYWORD_MAX_LEN = 6
) (
	input  logic         clk,
	input  logic         arst_n,
	input  logic         en,
	input  logic [7:0]   byte_in,
	output token_pair_t  res,
	output scan_status_t status
);

	localparam int POS_W = $clog2(MAX_TEXT_LEN);
	localparam int EXT_W = (POS_W > 16) ? POS_W : 16;
	localparam int IDX_W = $clog2(KEYWORD_MAX_LEN);
	localparam logic [POS_W:0]   MAX_W   = (POS_W + 1)'(MAX_TEXT_LEN);
	localparam logic [POS_W-1:0] POS_TOP = POS_W'(MAX_TEXT_LEN - 1);
	localparam logic [POS_W-1:0] KMAX_P  = POS_W'(KEYWORD_MAX_LEN);

	logic [2:0]       mode_q, mode_d;
	logic [POS_W-1:0] pos_q, pos_d;
	logic [POS_W-1:0] start_q, start_d;
	logic [31:0]      acc_q, acc_d;
	logic [7:0]       prefix_q [KEYWORD_MAX_LEN];

	logic             pf_we;
	logic [IDX_W-1:0] pf_idx;
	logic [POS_W-1:0] cur_span, pos_inc;
	logic [35:0]      acc_next;
	logic [31:0]      acc_sat;
	logic             kw_hit, kw_same;
	logic [2:0]       kw_code;
	logic             a_v, b_v, go_on;
	token_t           a_tok, b_tok, id_tok;

	// distance from one position to a later one, modulo the text length
	function automatic logic [POS_W-1:0] span(input logic [POS_W-1:0] from_p,
		input logic [POS_W-1:0] to_p);
		logic [POS_W:0] w;
		if (to_p >= from_p) begin
			w = {1'b0, to_p} - {1'b0, from_p};
		end else begin
			w = {1'b0, to_p} + MAX_W - {1'b0, from_p};
		end
		return w[POS_W-1:0];
	endfunction

	function automatic logic [15:0] to16(input logic [POS_W-1:0] v);
		logic [EXT_W-1:0] e;
		e = EXT_W'(v);
		return e[15:0];
	endfunction

	function automatic token_t mk_tok(input logic [2:0] kind, input logic [15:0] off,
		input logic [15:0] len, input logic [31:0] val, input logic [2:0] code);
		token_t t;
		t.kind   = kind;
		t.offset = off;
		t.length = len;
		t.value  = val;
		t.code   = code;
		t.last   = 1'b0;
		return t;
	endfunction

	assign cur_span = span(start_q, pos_q);
	assign pos_inc  = (pos_q == POS_TOP) ? '0 : pos_q + 1'b1;

	// decimal accumulate with saturation
	assign acc_next = 36'({acc_q, 3'b000}) + 36'({acc_q, 1'b0}) + 36'(byte_in[3:0]);
	assign acc_sat  = (acc_next[35:32] != 4'd0) ? 32'hFFFF_FFFF : acc_next[31:0];

	// keyword match against the stored prefix
	always_comb begin
		kw_hit  = 1'b0;
		kw_code = 3'd0;
		kw_same = 1'b0;
		for (int k = 0; k < KW_COUNT; k++) begin
			kw_same = (cur_span == POS_W'(KW_LEN[k]));
			for (int i = 0; i < KW_MAX_LEN; i++) begin
				if (i < KW_LEN[k] && prefix_q[i] != KW_CHARS[k][i]) begin
					kw_same = 1'b0;
				end
			end
			if (kw_same && !kw_hit) begin
				kw_hit  = 1'b1;
				kw_code = 3'(k);
			end
		end
	end

	assign id_tok = kw_hit ?
		mk_tok(KIND_KEYWORD, to16(start_q), to16(cur_span), 32'd0, kw_code) :
		mk_tok(KIND_IDENT, to16(start_q), to16(cur_span), 32'd0, 3'd0);

	// close the open token, then lex the byte itself
	always_comb begin
		mode_d  = mode_q;
		pos_d   = pos_q;
		start_d = start_q;
		acc_d   = acc_q;
		pf_we   = 1'b0;
		pf_idx  = '0;
		a_v     = 1'b0;
		a_tok   = '0;
		b_v     = 1'b0;
		b_tok   = '0;
		go_on   = 1'b1;

		case (mode_q)
			MODE_IDENT: begin
				if (is_letter(byte_in) || byte_in == CH_UNDER) begin
					if (cur_span < KMAX_P) begin
						pf_we  = 1'b1;
						pf_idx = cur_span[IDX_W-1:0];
					end
					pos_d = pos_inc;
					go_on = 1'b0;
				end else begin
					a_v    = 1'b1;
					a_tok  = id_tok;
					mode_d = MODE_IDLE;
				end
			end
			MODE_NUMBER: begin
				if (is_digit(byte_in)) begin
					acc_d = acc_sat;
					pos_d = pos_inc;
					go_on = 1'b0;
				end else begin
					a_v    = 1'b1;
					a_tok  = mk_tok(KIND_NUMBER, to16(start_q), to16(cur_span), acc_q, 3'd0);
					mode_d = MODE_IDLE;
				end
			end
			MODE_STRING: begin
				if (byte_in == CH_QUOTE) begin
					a_v    = 1'b1;
					a_tok  = mk_tok(KIND_STRING, to16(start_q), to16(cur_span), 32'd0, 3'd0);
					mode_d = MODE_IDLE;
					pos_d  = pos_inc;
					go_on  = 1'b0;
				end else if (byte_in != CH_NUL) begin
					pos_d = pos_inc;
					go_on = 1'b0;
				end else begin
					// text ended inside the string
					a_v    = 1'b1;
					a_tok  = mk_tok(KIND_ERROR, to16(start_q), to16(cur_span), 32'd0, 3'd0);
					mode_d = MODE_IDLE;
				end
			end
			MODE_BANG: begin
				if (byte_in == CH_EQUAL) begin
					a_v    = 1'b1;
					a_tok  = mk_tok(KIND_PUNCT, to16(start_q), 16'd2, 32'd0, 3'd0);
					mode_d = MODE_IDLE;
					pos_d  = pos_inc;
					go_on  = 1'b0;
				end else begin
					a_v    = 1'b1;
					a_tok  = mk_tok(KIND_PUNCT, to16(start_q), 16'd1, 32'd0, 3'd0);
					mode_d = MODE_IDLE;
				end
			end
			default: begin
				mode_d = MODE_IDLE;
			end
		endcase

		if (go_on) begin
			if (byte_in == CH_NUL) begin
				b_v     = 1'b1;
				b_tok   = mk_tok(KIND_EOF, to16(pos_q), 16'd0, 32'd0, 3'd0);
				mode_d  = MODE_IDLE;
				pos_d   = '0;
				start_d = '0;
				acc_d   = '0;
			end else begin
				if (is_blank(byte_in)) begin
					mode_d = mode_d;
				end else if (byte_in == CH_QUOTE) begin
					mode_d  = MODE_STRING;
					start_d = pos_inc;
				end else if (byte_in == CH_BANG) begin
					mode_d  = MODE_BANG;
					start_d = pos_q;
				end else if (is_punct(byte_in)) begin
					b_v   = 1'b1;
					b_tok = mk_tok(KIND_PUNCT, to16(pos_q), 16'd1, 32'd0, 3'd0);
				end else if (is_digit(byte_in)) begin
					mode_d  = MODE_NUMBER;
					start_d = pos_q;
					acc_d   = 32'(byte_in[3:0]);
				end else if (is_letter(byte_in)) begin
					mode_d  = MODE_IDENT;
					start_d = pos_q;
					pf_we   = 1'b1;
					pf_idx  = '0;
				end else begin
					b_v   = 1'b1;
					b_tok = mk_tok(KIND_ERROR, to16(pos_q), 16'd1, 32'd0, 3'd0);
				end
				pos_d = pos_inc;
			end
		end
	end

	// compact results into low slots and mark the last one
	always_comb begin
		res.cnt    = 2'(a_v) + 2'(b_v);
		res.tok[0] = a_v ? a_tok : b_tok;
		res.tok[1] = b_tok;
		res.tok[0].last = (res.cnt == 2'd1);
		res.tok[1].last = 1'b1;
	end

	assign status.mode   = mode_q;
	assign status.pos_lo = to16(pos_q);

	// scan state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			mode_q  <= MODE_IDLE;
			pos_q   <= '0;
			start_q <= '0;
			acc_q   <= '0;
		end else if (en) begin
			mode_q  <= mode_d;
			pos_q   <= pos_d;
			start_q <= start_d;
			acc_q   <= acc_d;
		end
	end

	// identifier prefix characters
	always_ff @(posedge clk) begin
		for (int i = 0; i < KEYWORD_MAX_LEN; i++) begin
			if (en && pf_we && pf_idx == IDX_W'(i)) begin
				prefix_q[i] <= byte_in;
			end
		end
	end

endmodule

/* hw/rtl/sqlq_outq.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sqlq_outq - token result queue
// Takes up to two tokens per cycle and hands out one beat per cycle while pop is high.
// ----------------------------------------------------------------------------
module sqlq_outq
	import sqlq_pkg::*;
(
	input  logic              clk,
	input  logic              arst_n,
	input  logic              push,
	input  token_pair_t       din,
	input  logic              pop,
	output token_t            head,
	output logic              not_empty,
	output logic [QCNT_W-1:0] count
);

	token_t            mem_q [QUEUE_DEPTH];
	logic [QPTR_W-1:0] wptr_q, rptr_q;
	logic [QCNT_W-1:0] count_q;
	logic [1:0]        push_cnt;
	logic              do_pop;

	assign push_cnt  = push ? din.cnt : 2'd0;
	assign not_empty = (count_q != '0);
	assign do_pop    = pop && not_empty;
	assign head      = mem_q[rptr_q];
	assign count     = count_q;

	// storage write, up to two entries
	always_ff @(posedge clk) begin
		if (push_cnt != 2'd0) begin
			mem_q[wptr_q] <= din.tok[0];
		end
		if (push_cnt == 2'd2) begin
			mem_q[wptr_q + 1'b1] <= din.tok[1];
		end
	end

	// pointers and fill level
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wptr_q  <= '0;
			rptr_q  <= '0;
			count_q <= '0;
		end else begin
			wptr_q  <= wptr_q + QPTR_W'(push_cnt);
			rptr_q  <= rptr_q + QPTR_W'(do_pop);
			count_q <= count_q + QCNT_W'(push_cnt) - QCNT_W'(do_pop);
		end
	end

endmodule

/* hw/rtl/sql_query_lexer.sv */
`timescale 1ns / 1ps
// Path: an accepted text byte is registered, lexed, and its token beats are queued for output.
// Throughput: one byte per cycle while s_tready is high; the output side moves one token
// beat per cycle while m_tready is high, so bytes that close one token and are themselves
// a one-byte token (two beats) are paced by the output port.
// s_tready drops while more than four beats wait in the eight-entry result queue.
// Reset: arst_n clears the scan state to idle at position zero and empties the queue.
// ----------------------------------------------------------------------------
// sql_query_lexer - streaming lexer for query text
// One byte per beat in, one token per beat out, zero byte closes the text.
// ----------------------------------------------------------------------------
module sql_query_lexer
	import sqlq_pkg::*;
#(
	parameter int MAX_TEXT_LEN    = 65536,
	parameter int KEYWORD_MAX_LEN = 6
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        s_tvalid,
	output logic        s_tready,
	input  logic [7:0]  s_tdata,   // [7:0] text_byte
	output logic        m_tvalid,
	input  logic        m_tready,
	output logic [71:0] m_tdata,   // [2:0] token_kind, [18:3] token_offset,
	                               // [34:19] token_length, [66:35] number_value,
	                               // [69:67] keyword_code, [71:70] zero
	output logic        m_tlast    // run_last
);

	logic              valid_s1;
	logic [7:0]        byte_s1;
	token_pair_t       res;
	scan_status_t      status;
	token_t            head;
	logic [QCNT_W-1:0] q_count;

	assign s_tready = (q_count <= QUEUE_ACCEPT_MAX);

	// input register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else begin
			valid_s1 <= s_tvalid && s_tready;
		end
	end

	always_ff @(posedge clk) begin
		if (s_tvalid && s_tready) begin
			byte_s1 <= s_tdata;
		end
	end

	// lexer core
	sqlq_scan #(
		.MAX_TEXT_LEN    (MAX_TEXT_LEN),
		.KEYWORD_MAX_LEN (KEYWORD_MAX_LEN)
	) u_scan (
		.clk     (clk),
		.arst_n  (arst_n),
		.en      (valid_s1),
		.byte_in (byte_s1),
		.res     (res),
		.status  (status)
	);

	// result queue
	sqlq_outq u_outq (
		.clk       (clk),
		.arst_n    (arst_n),
		.push      (valid_s1),
		.din       (res),
		.pop       (m_tready),
		.head      (head),
		.not_empty (m_tvalid),
		.count     (q_count)
	);

	// output beat
	assign m_tdata = {2'b00, head.code, head.value, head.length, head.offset, head.kind};
	assign m_tlast = head.last;

	// queue never overfills
	a_queue_bound: assert property (@(posedge clk) disable iff (!arst_n)
		q_count <= QCNT_W'(QUEUE_DEPTH))
		else $error("result queue overfilled");

	// a zero byte always yields at least the end token
	a_eof_emits: assert property (@(posedge clk) disable iff (!arst_n)
		valid_s1 && byte_s1 == CH_NUL |-> res.cnt != 2'd0 && res.cnt != 2'd3)
		else $error("zero byte gave no token");

	// after the end of text the scanner is idle at position zero
	a_eof_resets: assert property (@(posedge clk) disable iff (!arst_n)
		valid_s1 && byte_s1 == CH_NUL |=> status.mode == MODE_IDLE && status.pos_lo == 16'd0)
		else $error("scanner not reset after end of text");

endmodule
